[rtl/id3fp_pkg.sv]
`timescale 1ns / 1ps
package id3fp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] frame_id;
      logic [31:0] frame_size;
      logic [15:0] frame_flags;
      logic [28:0] body_offset;
      logic [1:0]  frame_class;
      logic [7:0]  major_version;
      logic [2:0]  end_status;
      logic        is_last;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_HDR,
      PH_ID,
      PH_SIZE,
      PH_FLAGS,
      PH_SKIP,
      PH_DONE
   } phase_type;

   localparam logic       KIND_FRAME  = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;

   localparam logic [2:0] ST_PADDING   = 3'd0;
   localparam logic [2:0] ST_EXACT_END = 3'd1;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [2:0] ST_SIZE_BYTE = 3'd3;
   localparam logic [2:0] ST_SHORT     = 3'd4;
   localparam logic [2:0] ST_NOT_ID3   = 3'd5;
   localparam logic [2:0] ST_TOO_NEW   = 3'd6;

   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_TEXT  = 2'd1;
   localparam logic [1:0] CLS_COMM  = 2'd2;
   localparam logic [1:0] CLS_OTHER = 2'd3;

   localparam logic [23:0] TAG_MARK    = 24'h494433;
   localparam logic [31:0] ID_DEFAULT  = 32'h54585858;
   localparam logic [3:0]  HDR_LEN     = 4'd10;
   localparam logic [3:0]  FLAGS_LEN   = 4'd2;
   localparam logic [7:0]  REG_CFG_MAX = 8'd0;
   localparam logic [7:0]  MAX_VER_RST = 8'd4;

   // Map a three-character ID to its four-character form
   function automatic logic [31:0] convert_three(input logic [23:0] three);
      logic [31:0] four;
      unique case (three)
         "CRA": four = "AENC";  "PIC": four = "APIC";  "COM": four = "COMM";
         "EQU": four = "EQUA";  "ETC": four = "ETCO";  "GEO": four = "GEOB";
         "IPL": four = "IPLS";  "LNK": four = "LINK";  "MCI": four = "MCDI";
         "MLL": four = "MLLT";  "CNT": four = "PCNT";  "POP": four = "POPM";
         "BUF": four = "RBUF";  "RVA": four = "RVAD";  "REV": four = "RVRB";
         "SLT": four = "SYLT";  "STC": four = "SYTC";  "TAL": four = "TALB";
         "TBP": four = "TBPM";  "TCM": four = "TCOM";  "TCO": four = "TCON";
         "TCR": four = "TCOP";  "TDY": four = "TDLY";  "TEN": four = "TENC";
         "TXT": four = "TEXT";  "TFT": four = "TFLT";  "TIM": four = "TIME";
         "TT1": four = "TIT1";  "TT2": four = "TIT2";  "TT3": four = "TIT3";
         "TKE": four = "TKEY";  "TLA": four = "TLAN";  "TLE": four = "TLEN";
         "TMT": four = "TMED";  "TOT": four = "TOAL";  "TOF": four = "TOFN";
         "TOL": four = "TOLY";  "TOA": four = "TOPE";  "TOR": four = "TORY";
         "TP1": four = "TPE1";  "TP2": four = "TPE2";  "TP3": four = "TPE3";
         "TP4": four = "TPE4";  "TPA": four = "TPOS";  "TPB": four = "TPUB";
         "TRK": four = "TRCK";  "TRD": four = "TRDA";  "TSI": four = "TSIZ";
         "TRC": four = "TSRC";  "TSS": four = "TSSE";  "TXX": four = "TXXX";
         "TYE": four = "TYER";  "UFI": four = "UFID";  "ULT": four = "USLT";
         "WCM": four = "WCOM";  "WCP": four = "WCOP";  "WAF": four = "WOAF";
         "WAR": four = "WOAR";  "WAS": four = "WOAS";  "WPB": four = "WPUB";
         "WXX": four = "WXXX";
         default: four = ID_DEFAULT;
      endcase
      return four;
   endfunction

   // Classify a four-character ID
   function automatic logic [1:0] class_of(input logic [31:0] four);
      logic [1:0] cls;
      unique case (four)
         "COMM": cls = CLS_COMM;
         "TALB", "TBPM", "TCOM", "TCON", "TCOP", "TDAT", "TDEN", "TDLY",
         "TDOR", "TDRC", "TDRL", "TDTG", "TENC", "TEXT", "TFLT", "TIME",
         "TIPL", "TIT1", "TIT2", "TIT3", "TKEY", "TLAN", "TLEN", "TMCL",
         "TMED", "TMOO", "TOAL", "TOFN", "TOLY", "TOPE", "TORY", "TOWN",
         "TPE1", "TPE2", "TPE3", "TPE4", "TPOS", "TPRO", "TPUB", "TRCK",
         "TRDA", "TRSN", "TRSO", "TSIZ", "TSOA", "TSOP", "TSOT", "TSRC",
         "TSSE", "TSST", "TYER": cls = CLS_TEXT;
         "AENC", "APIC", "ASPI", "COMR", "ENCR", "EQUA", "EQU2", "ETCO",
         "GEOB", "GRID", "IPLS", "LINK", "MCDI", "MLLT", "OWNE", "PRIV",
         "PCNT", "POPM", "POSS", "RBUF", "RVAD", "RVA2", "RVRB", "SEEK",
         "SIGN", "SYLT", "SYTC", "TXXX", "UFID", "USER", "USLT", "WCOM",
         "WCOP", "WOAF", "WOAR", "WOAS", "WORS", "WPAY", "WPUB",
         "WXXX": cls = CLS_OTHER;
         default: cls = CLS_NONE;
      endcase
      return cls;
   endfunction

   function automatic rsp_type mk_status(input logic [7:0] ver, input logic [2:0] st);
      rsp_type r;
      r = '0;
      r.kind          = KIND_STATUS;
      r.major_version = ver;
      r.end_status    = st;
      return r;
   endfunction

endpackage

[rtl/id3v2_frame_header_parser.sv]
`timescale 1ns / 1ps
// Channel   Direction  Beat       Handshake
// req_      in         req_type   req_valid / req_stall
// rsp_      out        rsp_type   rsp_valid / rsp_stall
// csr_      in         max_version at address 0, APB write
//
// One file byte per cycle unless stalled: a byte is held in the input register
// and its up to two results are written into a four-entry result queue, from
// which they are shown. Synchronous reset clears the walk, the queue and sets
// max_version to 4. The input stalls only while the result queue holds more
// than two beats.
module id3v2_frame_header_parser #(
   parameter int POSITION_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  id3fp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output id3fp_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import id3fp_pkg::*;

   logic [7:0] maxv_ff;
   logic       space;
   logic [1:0] push_count;
   rsp_type    push0, push1;
   logic       reg_hit;

   // Register access
   assign csr_pready = 1'b1;
   assign reg_hit    = {5'd0, csr_paddr} == {REG_CFG_MAX[5:0], 2'b00};
   assign csr_prdata = reg_hit ? {24'd0, maxv_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) maxv_ff <= MAX_VER_RST;
      else if (csr_psel & csr_penable & csr_pwrite & reg_hit) maxv_ff <= csr_pwdata[7:0];
   end

   id3fp_core #(.POSITION_BITS(POSITION_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .max_version(maxv_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .space      (space),
      .push_count (push_count),
      .push0      (push0),
      .push1      (push1)
   );

   id3fp_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push_count(push_count),
      .push0     (push0),
      .push1     (push1),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/id3fp_rspq.sv]
`timescale 1ns / 1ps
module id3fp_rspq (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  id3fp_pkg::rsp_type push0,
   input  id3fp_pkg::rsp_type push1,
   output logic               space,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output id3fp_pkg::rsp_type rsp_data
);
   import id3fp_pkg::*;

   rsp_type    q_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign space     = cnt_ff <= 3'd2;
   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_data  = q_ff[rd_ff];
   assign pop       = rsp_valid & ~rsp_stall;

   // Advance pointers and fill count
   always_comb begin
      wr_in  = wr_ff + push_count;
      rd_in  = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Write up to two beats per cycle
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) q_ff[wr_ff] <= push0;
      if (push_count == 2'd2) q_ff[wr_ff + 2'd1] <= push1;
   end

endmodule

[rtl/id3fp_core.sv]
`timescale 1ns / 1ps
module id3fp_core #(
   parameter int POSITION_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         max_version,
   input  logic               req_valid,
   output logic               req_stall,
   input  id3fp_pkg::req_type req_data,
   input  logic               space,
   output logic [1:0]         push_count,
   output id3fp_pkg::rsp_type push0,
   output id3fp_pkg::rsp_type push1
);
   import id3fp_pkg::*;

   localparam int SW = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 2;

   // Input register
   logic    in_full_ff, in_full_in, proceed;
   req_type in_ff;

   // Walk state
   phase_type              phase_ff, phase_in;
   logic [3:0]             fc_ff, fc_in, fc_inc, idlen;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [28:0]            tag_end_ff, tag_end_in;
   logic [7:0]             ver_ff, ver_in, b;
   logic [31:0]            id_ff, id_in, size_ff, size_in, skip_ff, skip_in, sk;
   logic [15:0]            flags_ff, flags_in;
   logic                   bad_ff, bad_in, v2;

   // Frame completion terms
   logic [31:0]   size_cand, fd_id;
   logic [15:0]   flags_cand;
   logic [SW-1:0] body_w, stop_w, tag_end_w;
   rsp_type       desc;

   assign req_stall  = in_full_ff & ~space;
   assign proceed    = in_full_ff & space;
   assign in_full_in = (req_valid & ~req_stall) | (in_full_ff & ~proceed);

   always_ff @(posedge clock) begin
      if (reset) in_full_ff <= 1'b0;
      else       in_full_ff <= in_full_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) in_ff <= req_data;
   end

   assign b      = in_ff.data_byte;
   assign v2     = ver_ff <= 8'd2;
   assign idlen  = v2 ? 4'd3 : 4'd4;
   assign fc_inc = fc_ff + 4'd1;
   assign sk     = (skip_ff != 32'd0) ? skip_ff - 32'd1 : skip_ff;

   // Size and flags as they stand once this byte is folded in
   always_comb begin
      size_cand = size_ff;
      if (phase_ff == PH_SIZE) begin
         if (ver_ff > 8'd3) size_cand = {size_ff[24:0], b[6:0]};
         else               size_cand = {size_ff[23:0], b};
      end
      flags_cand = (phase_ff == PH_FLAGS) ? {flags_ff[7:0], b} : flags_ff;
   end

   // Build the descriptor for a completed frame header
   always_comb begin
      body_w    = SW'(pos_ff) + SW'(1);
      stop_w    = body_w + SW'(size_cand);
      tag_end_w = SW'(tag_end_ff);
      fd_id     = v2 ? convert_three(id_ff[23:0]) : id_ff;
      desc               = '0;
      desc.kind          = KIND_FRAME;
      desc.frame_id      = fd_id;
      desc.frame_size    = size_cand;
      desc.frame_flags   = v2 ? 16'd0 : flags_cand;
      desc.body_offset   = body_w[28:0];
      desc.frame_class   = class_of(fd_id);
      desc.major_version = ver_ff;
   end

   // Step the walk by one byte
   always_comb begin
      phase_in   = phase_ff;
      fc_in      = fc_ff;
      pos_in     = (pos_ff == {POSITION_BITS{1'b1}}) ? pos_ff : pos_ff + 1'b1;
      tag_end_in = tag_end_ff;
      ver_in     = ver_ff;
      id_in      = id_ff;
      size_in    = size_ff;
      flags_in   = flags_ff;
      bad_in     = bad_ff;
      skip_in    = skip_ff;
      push_count = 2'd0;
      push0      = '0;
      push1      = '0;

      unique case (phase_ff)
         PH_HDR: begin
            if (fc_ff < 4'd3)       id_in   = {id_ff[23:0], b};
            else if (fc_ff == 4'd3) ver_in  = b;
            else if (fc_ff >= 4'd6) size_in = {size_ff[24:0], b[6:0]};
            fc_in = fc_inc;
            if (fc_inc >= HDR_LEN) begin
               if (id_in[23:0] != TAG_MARK) begin
                  push0 = mk_status(ver_in, ST_NOT_ID3);
                  push_count = 2'd1;
                  phase_in = PH_DONE;
               end else begin
                  tag_end_in = {1'b0, size_in[27:0]} + 29'd10;
                  if (ver_in > max_version) begin
                     push0 = mk_status(ver_in, ST_TOO_NEW);
                     push_count = 2'd1;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_ID;
                     fc_in    = '0;
                     id_in    = '0;
                  end
               end
            end
         end
         PH_ID: begin
            if (fc_ff == 4'd0 && b == 8'd0) begin
               push0 = mk_status(ver_ff, ST_PADDING);
               push_count = 2'd1;
               phase_in = PH_DONE;
            end else begin
               id_in = {id_ff[23:0], b};
               fc_in = fc_inc;
               if (fc_inc >= idlen) begin
                  phase_in = PH_SIZE;
                  fc_in    = '0;
                  size_in  = '0;
                  bad_in   = 1'b0;
               end
            end
         end
         PH_SIZE, PH_FLAGS: begin
            size_in  = size_cand;
            flags_in = flags_cand;
            if (phase_ff == PH_SIZE && ver_ff > 8'd3) bad_in = bad_ff | b[7];
            fc_in = fc_inc;
            if (fc_inc >= ((phase_ff == PH_SIZE) ? idlen : FLAGS_LEN)) begin
               fc_in = '0;
               if (phase_ff == PH_SIZE && bad_in) begin
                  push0 = mk_status(ver_ff, ST_SIZE_BYTE);
                  push_count = 2'd1;
                  phase_in = PH_DONE;
               end else if (phase_ff == PH_SIZE && !v2) begin
                  phase_in = PH_FLAGS;
                  flags_in = '0;
               end else if (size_cand == 32'd0 || stop_w > tag_end_w) begin
                  push0 = mk_status(ver_ff, ST_BAD_SIZE);
                  push_count = 2'd1;
                  phase_in = PH_DONE;
               end else begin
                  push0 = desc;
                  push_count = 2'd1;
                  if (stop_w == tag_end_w) begin
                     push1 = mk_status(ver_ff, ST_EXACT_END);
                     push_count = 2'd2;
                     phase_in = PH_DONE;
                  end else begin
                     skip_in  = size_cand;
                     phase_in = PH_SKIP;
                  end
               end
            end
         end
         PH_SKIP: begin
            skip_in = sk;
            if (sk == 32'd0) begin
               phase_in = PH_ID;
               fc_in    = '0;
               id_in    = '0;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // End of file: close the walk and rearm
      if (in_ff.last_byte) begin
         if (phase_in != PH_DONE) begin
            if (push_count == 2'd0) begin
               push0 = mk_status(ver_in, (phase_in == PH_HDR) ? ST_SHORT : ST_PADDING);
               push_count = 2'd1;
            end else begin
               push1 = mk_status(ver_in, (phase_in == PH_HDR) ? ST_SHORT : ST_PADDING);
               push_count = 2'd2;
            end
         end
         phase_in   = PH_HDR;
         fc_in      = '0;
         pos_in     = '0;
         tag_end_in = '0;
         ver_in     = '0;
         id_in      = '0;
         size_in    = '0;
         flags_in   = '0;
         bad_in     = 1'b0;
         skip_in    = '0;
      end

      // Mark the final beat of this byte
      if (push_count == 2'd1) push0.is_last = 1'b1;
      if (push_count == 2'd2) push1.is_last = 1'b1;
      if (!proceed) push_count = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR;
         fc_ff      <= '0;
         pos_ff     <= '0;
         tag_end_ff <= '0;
         ver_ff     <= '0;
         id_ff      <= '0;
         size_ff    <= '0;
         flags_ff   <= '0;
         bad_ff     <= 1'b0;
         skip_ff    <= '0;
      end else if (proceed) begin
         phase_ff   <= phase_in;
         fc_ff      <= fc_in;
         pos_ff     <= pos_in;
         tag_end_ff <= tag_end_in;
         ver_ff     <= ver_in;
         id_ff      <= id_in;
         size_ff    <= size_in;
         flags_ff   <= flags_in;
         bad_ff     <= bad_in;
         skip_ff    <= skip_in;
      end
   end

endmodule
